### rtl/core/cstl_pkg.sv
// shared types, token codes and character helpers for the c subset token lexer
package cstl_pkg;

    typedef struct packed {
        logic [7:0] source_char;
        logic       end_of_source;
    } in_word_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] start_pos;
        logic [15:0] token_length;
        logic        run_last;
    } out_word_t;

    localparam logic [3:0] KIND_LBRACE = 4'd0;
    localparam logic [3:0] KIND_RBRACE = 4'd1;
    localparam logic [3:0] KIND_LPAREN = 4'd2;
    localparam logic [3:0] KIND_RPAREN = 4'd3;
    localparam logic [3:0] KIND_SEMI   = 4'd4;
    localparam logic [3:0] KIND_INT    = 4'd5;
    localparam logic [3:0] KIND_VOID   = 4'd6;
    localparam logic [3:0] KIND_RETURN = 4'd7;
    localparam logic [3:0] KIND_CONST  = 4'd8;
    localparam logic [3:0] KIND_IDENT  = 4'd9;
    localparam logic [3:0] KIND_END    = 4'd10;
    localparam logic [3:0] KIND_BAD    = 4'd11;
    localparam logic [3:0] KIND_OPEN   = 4'd12;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    localparam int NUM_KW = 3;
    localparam logic [2:0] KW_ALL = 3'b111;
    localparam logic [2:0] KW_LEN_INT    = 3'd3;
    localparam logic [2:0] KW_LEN_VOID   = 3'd4;
    localparam logic [2:0] KW_LEN_RETURN = 3'd6;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int MAX_RES    = 3;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == CH_UNDER);
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] r;
        case (k)
            2'd0:    r = KW_LEN_INT;
            2'd1:    r = KW_LEN_VOID;
            default: r = KW_LEN_RETURN;
        endcase
        return r;
    endfunction

    // keyword text, one byte per position
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] i);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            2'd0: begin
                case (i)
                    3'd0:    r = 8'h69; // i
                    3'd1:    r = 8'h6E; // n
                    3'd2:    r = 8'h74; // t
                    default: r = 8'h00;
                endcase
            end
            2'd1: begin
                case (i)
                    3'd0:    r = 8'h76; // v
                    3'd1:    r = 8'h6F; // o
                    3'd2:    r = 8'h69; // i
                    3'd3:    r = 8'h64; // d
                    default: r = 8'h00;
                endcase
            end
            default: begin
                case (i)
                    3'd0:    r = 8'h72; // r
                    3'd1:    r = 8'h65; // e
                    3'd2:    r = 8'h74; // t
                    3'd3:    r = 8'h75; // u
                    3'd4:    r = 8'h72; // r
                    3'd5:    r = 8'h6E; // n
                    default: r = 8'h00;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/core/c_subset_token_lexer_top.sv
// streaming lexer for a small c subset: mode register plus result queue
//
// input channel (in_valid/in_ready/in_data) takes one source character per
// word, with end_of_source on the final one. output channel
// (out_valid/out_ready/out_data) gives token words: kind, start offset,
// length and run_last on the last word caused by a character.
// a character is lexed in the cycle it is accepted; its zero to three
// result words are written to an 8-entry queue at that edge and are read
// in order from the head of the queue on out_data. one character per
// cycle is taken while the queue has room for three words, and one word
// leaves per cycle while out_ready is high, so sustained rate is one
// character per cycle unless tokens come faster than one per cycle. a
// stalled receiver fills the queue and then drops in_ready; nothing is
// lost. reset empties the queue and returns the lexer to idle at offset
// zero; the end word of a source does the same for the lexer state.
module c_subset_token_lexer_top #(
    parameter int POS_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cstl_pkg::in_word_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cstl_pkg::out_word_t out_data
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_SLASH,
        MODE_LINE,
        MODE_BLOCK,
        MODE_STAR,
        MODE_NUM,
        MODE_WORD,
        MODE_ERR
    } mode_t;

    typedef logic [POS_WIDTH-1:0] pos_t;

    mode_t      mode_reg, mode_next;
    pos_t       pos_reg, pos_next;
    pos_t       start_reg, start_next;
    pos_t       len_reg, len_next;
    logic [2:0] cand_reg, cand_next;

    logic [cstl_pkg::FIFO_AW-1:0] wr_reg, wr_next;
    logic [cstl_pkg::FIFO_AW-1:0] rd_reg, rd_next;
    logic [cstl_pkg::FIFO_AW:0]   cnt_reg, cnt_next;

    cstl_pkg::out_word_t mem [cstl_pkg::FIFO_DEPTH];
    cstl_pkg::out_word_t res [cstl_pkg::MAX_RES];
    logic [1:0]          res_cnt;

    logic in_fire, out_fire;

    function automatic pos_t sat_inc(input pos_t v);
        return (&v) ? v : v + POS_WIDTH'(1);
    endfunction

    function automatic logic [15:0] cap16(input pos_t v);
        logic [32:0] wide;
        wide = 33'(v);
        return (|wide[32:16]) ? 16'hFFFF : wide[15:0];
    endfunction

    assign in_ready  = cnt_reg <= (cstl_pkg::FIFO_AW + 1)'(cstl_pkg::FIFO_DEPTH
                                   - cstl_pkg::MAX_RES);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = cnt_reg != '0;
    assign out_fire  = out_valid && out_ready;
    assign out_data  = mem[rd_reg];

    always_comb
    begin
        logic [7:0] c;
        logic       last;
        logic       again;
        pos_t       p;
        logic [3:0] kind;

        c          = in_data.source_char;
        last       = in_data.end_of_source;
        again      = 1'b0;
        p          = pos_reg;
        kind       = cstl_pkg::KIND_IDENT;
        mode_next  = mode_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        len_next   = len_reg;
        cand_next  = cand_reg;
        res_cnt    = 2'd0;
        for (int j = 0; j < cstl_pkg::MAX_RES; j++)
        begin
            res[j] = '0;
        end

        if (in_fire)
        begin
            pos_next = sat_inc(pos_reg);

            unique case (mode_reg)
                MODE_IDLE:
                begin
                    again = 1'b1;
                end
                MODE_WORD:
                begin
                    if (cstl_pkg::is_alpha(c) || cstl_pkg::is_digit(c))
                    begin
                        for (int k = 0; k < cstl_pkg::NUM_KW; k++)
                        begin
                            if (len_next >= pos_t'(cstl_pkg::kw_len(2'(k)))
                                || cstl_pkg::kw_char(2'(k), len_next[2:0]) != c)
                            begin
                                cand_next[k] = 1'b0;
                            end
                        end
                        len_next = sat_inc(len_next);
                    end
                    else
                    begin
                        kind = cstl_pkg::KIND_IDENT;
                        for (int k = 0; k < cstl_pkg::NUM_KW; k++)
                        begin
                            if (cand_next[k]
                                && len_next == pos_t'(cstl_pkg::kw_len(2'(k))))
                            begin
                                kind = cstl_pkg::KIND_INT + 4'(k);
                            end
                        end
                        res[res_cnt] = '{kind, cap16(start_next), cap16(len_next), 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                        mode_next    = MODE_IDLE;
                        again        = 1'b1;
                    end
                end
                MODE_NUM:
                begin
                    if (cstl_pkg::is_digit(c))
                    begin
                        len_next = sat_inc(len_next);
                    end
                    else if (cstl_pkg::is_alpha(c))
                    begin
                        res[res_cnt] = '{cstl_pkg::KIND_BAD, cap16(start_next),
                                         cap16(sat_inc(len_next)), 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                        mode_next    = MODE_ERR;
                    end
                    else
                    begin
                        res[res_cnt] = '{cstl_pkg::KIND_CONST, cap16(start_next),
                                         cap16(len_next), 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                        mode_next    = MODE_IDLE;
                        again        = 1'b1;
                    end
                end
                MODE_SLASH:
                begin
                    if (c == cstl_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (c == cstl_pkg::CH_STAR)
                    begin
                        len_next  = POS_WIDTH'(2);
                        mode_next = MODE_BLOCK;
                    end
                    else
                    begin
                        res[res_cnt] = '{cstl_pkg::KIND_BAD, cap16(start_next), 16'd1, 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                        mode_next    = MODE_ERR;
                    end
                end
                MODE_LINE:
                begin
                    if (c == cstl_pkg::CH_NL)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_BLOCK:
                begin
                    len_next = sat_inc(len_next);
                    if (c == cstl_pkg::CH_STAR)
                    begin
                        mode_next = MODE_STAR;
                    end
                end
                MODE_STAR:
                begin
                    len_next = sat_inc(len_next);
                    if (c == cstl_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (c != cstl_pkg::CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                end
                MODE_ERR:
                begin
                    mode_next = MODE_ERR;
                end
                default:
                begin
                    mode_next = mode_reg;
                end
            endcase

            // character seen between tokens
            if (again)
            begin
                case (c)
                    cstl_pkg::CH_SPACE, cstl_pkg::CH_TAB, cstl_pkg::CH_NL:
                    begin
                        mode_next = MODE_IDLE;
                    end
                    cstl_pkg::CH_LBRACE:
                    begin
                        res[res_cnt] = '{cstl_pkg::KIND_LBRACE, cap16(p), 16'd1, 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                    end
                    cstl_pkg::CH_RBRACE:
                    begin
                        res[res_cnt] = '{cstl_pkg::KIND_RBRACE, cap16(p), 16'd1, 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                    end
                    cstl_pkg::CH_LPAREN:
                    begin
                        res[res_cnt] = '{cstl_pkg::KIND_LPAREN, cap16(p), 16'd1, 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                    end
                    cstl_pkg::CH_RPAREN:
                    begin
                        res[res_cnt] = '{cstl_pkg::KIND_RPAREN, cap16(p), 16'd1, 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                    end
                    cstl_pkg::CH_SEMI:
                    begin
                        res[res_cnt] = '{cstl_pkg::KIND_SEMI, cap16(p), 16'd1, 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                    end
                    cstl_pkg::CH_SLASH:
                    begin
                        start_next = p;
                        len_next   = POS_WIDTH'(1);
                        mode_next  = MODE_SLASH;
                    end
                    default:
                    begin
                        start_next = p;
                        if (cstl_pkg::is_digit(c))
                        begin
                            len_next  = POS_WIDTH'(1);
                            mode_next = MODE_NUM;
                        end
                        else if (cstl_pkg::is_alpha(c))
                        begin
                            cand_next = cstl_pkg::KW_ALL;
                            for (int k = 0; k < cstl_pkg::NUM_KW; k++)
                            begin
                                if (cstl_pkg::kw_char(2'(k), 3'd0) != c)
                                begin
                                    cand_next[k] = 1'b0;
                                end
                            end
                            len_next  = POS_WIDTH'(1);
                            mode_next = MODE_WORD;
                        end
                        else
                        begin
                            res[res_cnt] = '{cstl_pkg::KIND_BAD, cap16(p), 16'd1, 1'b0};
                            res_cnt      = res_cnt + 2'd1;
                            mode_next    = MODE_ERR;
                        end
                    end
                endcase
            end

            // close out the source
            if (last)
            begin
                unique case (mode_next)
                    MODE_WORD:
                    begin
                        kind = cstl_pkg::KIND_IDENT;
                        for (int k = 0; k < cstl_pkg::NUM_KW; k++)
                        begin
                            if (cand_next[k]
                                && len_next == pos_t'(cstl_pkg::kw_len(2'(k))))
                            begin
                                kind = cstl_pkg::KIND_INT + 4'(k);
                            end
                        end
                        res[res_cnt] = '{kind, cap16(start_next), cap16(len_next), 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                    end
                    MODE_NUM:
                    begin
                        res[res_cnt] = '{cstl_pkg::KIND_CONST, cap16(start_next),
                                         cap16(len_next), 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                    end
                    MODE_SLASH:
                    begin
                        res[res_cnt] = '{cstl_pkg::KIND_BAD, cap16(start_next), 16'd1, 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                    end
                    MODE_BLOCK, MODE_STAR:
                    begin
                        res[res_cnt] = '{cstl_pkg::KIND_OPEN, cap16(start_next),
                                         cap16(len_next), 1'b0};
                        res_cnt      = res_cnt + 2'd1;
                    end
                    default:
                    begin
                        kind = cstl_pkg::KIND_IDENT;
                    end
                endcase
                res[res_cnt] = '{cstl_pkg::KIND_END, cap16(sat_inc(p)), 16'd0, 1'b0};
                res_cnt      = res_cnt + 2'd1;
                mode_next    = MODE_IDLE;
                pos_next     = '0;
                start_next   = '0;
                len_next     = '0;
                cand_next    = cstl_pkg::KW_ALL;
            end

            if (res_cnt != 2'd0)
            begin
                res[res_cnt - 2'd1].run_last = 1'b1;
            end
        end
    end

    always_comb
    begin
        wr_next  = wr_reg + cstl_pkg::FIFO_AW'(res_cnt);
        rd_next  = out_fire ? rd_reg + cstl_pkg::FIFO_AW'(1) : rd_reg;
        cnt_next = cnt_reg + (cstl_pkg::FIFO_AW + 1)'(res_cnt)
                 - (cstl_pkg::FIFO_AW + 1)'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            cand_reg  <= cstl_pkg::KW_ALL;
            wr_reg    <= '0;
            rd_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            cand_reg  <= cand_next;
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            cnt_reg   <= cnt_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < cstl_pkg::MAX_RES; j++)
        begin
            if (2'(j) < res_cnt)
            begin
                mem[wr_reg + cstl_pkg::FIFO_AW'(j)] <= res[j];
            end
        end
    end

endmodule
